[src/sc2a_pkg.sv]
package sc2a_pkg;

    typedef logic [6:0] char_t;

    typedef struct packed {
        logic [1:0]      last_idx;
        char_t [3:0]     chars;
    } job_t;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CODE_PREFIX      = 8'hE0;
    localparam logic [7:0] CODE_RELEASE_BIT = 8'h80;
    localparam logic [7:0] CODE_KEY_MASK    = 8'h7F;
    localparam logic [7:0] CODE_CTRL_MAKE   = 8'h1D;
    localparam logic [7:0] CODE_CTRL_BREAK  = 8'h9D;
    localparam logic [7:0] CODE_LSHIFT_MAKE = 8'h2A;
    localparam logic [7:0] CODE_RSHIFT_MAKE = 8'h36;
    localparam logic [7:0] CODE_LSHIFT_BRK  = 8'hAA;
    localparam logic [7:0] CODE_RSHIFT_BRK  = 8'hB6;
    localparam logic [7:0] CODE_UP          = 8'h48;
    localparam logic [7:0] CODE_DOWN        = 8'h50;
    localparam logic [7:0] CODE_RIGHT       = 8'h4D;
    localparam logic [7:0] CODE_LEFT        = 8'h4B;
    localparam logic [7:0] CODE_HOME        = 8'h47;
    localparam logic [7:0] CODE_END         = 8'h4F;
    localparam logic [7:0] CODE_DELETE      = 8'h53;
    localparam logic [7:0] CODE_PAGE_UP     = 8'h49;
    localparam logic [7:0] CODE_PAGE_DOWN   = 8'h51;
    localparam logic [7:0] TABLE_LEN        = 8'd59;

    localparam char_t CHAR_NUL     = 7'h00;
    localparam char_t CHAR_ESC     = 7'h1B;
    localparam char_t CHAR_BRACKET = 7'h5B;
    localparam char_t CHAR_TILDE   = 7'h7E;
    localparam char_t CHAR_LOWER_A = 7'h61;
    localparam char_t CHAR_LOWER_Z = 7'h7A;
    localparam char_t CASE_OFFSET  = 7'd32;
    localparam char_t CTRL_MASK    = 7'h1F;

    localparam char_t PLAIN_MAP [0:63] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    localparam char_t SHIFT_MAP [0:63] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

endpackage

[src/sc2a_if.sv]
interface sc2a_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] scancode;

    modport source (output valid, output scancode, input ready);
    modport sink   (input valid, input scancode, output ready);
endinterface

interface sc2a_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] character;
    logic       last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

[src/sc2a_front.sv]
module sc2a_front
    import sc2a_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    sc2a_in_if.sink          codes,
    input  logic             queue_full,
    output logic             push,
    output job_t             push_job
);

    logic  shift_reg, shift_next;
    logic  ctrl_reg, ctrl_next;
    logic  ext_reg, ext_next;
    logic  accept;
    logic [7:0] code;
    char_t lookup;
    char_t upper;
    char_t ch;

    function automatic job_t escape3(input char_t final_ch);
        job_t j;
        j.last_idx = 2'd2;
        j.chars[0] = CHAR_ESC;
        j.chars[1] = CHAR_BRACKET;
        j.chars[2] = final_ch;
        j.chars[3] = CHAR_NUL;
        return j;
    endfunction

    function automatic job_t escape4(input char_t digit);
        job_t j;
        j.last_idx = 2'd3;
        j.chars[0] = CHAR_ESC;
        j.chars[1] = CHAR_BRACKET;
        j.chars[2] = digit;
        j.chars[3] = CHAR_TILDE;
        return j;
    endfunction

    assign codes.ready = !queue_full;
    assign accept      = codes.valid && codes.ready;
    assign code        = codes.scancode;

    always_comb
    begin
        lookup = shift_reg ? SHIFT_MAP[code[5:0]] : PLAIN_MAP[code[5:0]];
        upper  = (lookup >= CHAR_LOWER_A && lookup <= CHAR_LOWER_Z)
                 ? lookup - CASE_OFFSET : lookup;
        ch     = (ctrl_reg && upper[6:5] == 2'b10) ? (upper & CTRL_MASK) : lookup;
    end

    always_comb
    begin
        shift_next = shift_reg;
        ctrl_next  = ctrl_reg;
        ext_next   = ext_reg;
        push       = 1'b0;
        push_job   = '0;
        push_job.chars[0] = ch;
        if (accept)
        begin
            if (code == CODE_PREFIX)
            begin
                ext_next = 1'b1;
            end
            else if (ext_reg)
            begin
                ext_next = 1'b0;
                if ((code & CODE_RELEASE_BIT) != 8'd0)
                begin
                    if ((code & CODE_KEY_MASK) == CODE_CTRL_MAKE)
                        ctrl_next = 1'b0;
                end
                else
                begin
                    unique case (code)
                        CODE_UP:        begin push = 1'b1; push_job = escape3(7'h41); end
                        CODE_DOWN:      begin push = 1'b1; push_job = escape3(7'h42); end
                        CODE_RIGHT:     begin push = 1'b1; push_job = escape3(7'h43); end
                        CODE_LEFT:      begin push = 1'b1; push_job = escape3(7'h44); end
                        CODE_HOME:      begin push = 1'b1; push_job = escape3(7'h48); end
                        CODE_END:       begin push = 1'b1; push_job = escape3(7'h46); end
                        CODE_DELETE:    begin push = 1'b1; push_job = escape4(7'h33); end
                        CODE_PAGE_UP:   begin push = 1'b1; push_job = escape4(7'h35); end
                        CODE_PAGE_DOWN: begin push = 1'b1; push_job = escape4(7'h36); end
                        CODE_CTRL_MAKE: ctrl_next = 1'b1;
                        default:        ;
                    endcase
                end
            end
            else if (code == CODE_LSHIFT_MAKE || code == CODE_RSHIFT_MAKE)
            begin
                shift_next = 1'b1;
            end
            else if (code == CODE_LSHIFT_BRK || code == CODE_RSHIFT_BRK)
            begin
                shift_next = 1'b0;
            end
            else if (code == CODE_CTRL_MAKE)
            begin
                ctrl_next = 1'b1;
            end
            else if (code == CODE_CTRL_BREAK)
            begin
                ctrl_next = 1'b0;
            end
            else if (code < TABLE_LEN && lookup != CHAR_NUL)
            begin
                push = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= 1'b0;
            ctrl_reg  <= 1'b0;
            ext_reg   <= 1'b0;
        end
        else
        begin
            shift_reg <= shift_next;
            ctrl_reg  <= ctrl_next;
            ext_reg   <= ext_next;
        end
    end

    a_escape_shape: assert property (@(posedge clk) disable iff (!rst_n)
        push && push_job.last_idx != 2'd0 |-> push_job.chars[0] == CHAR_ESC)
        else $error("multi-character transaction without escape lead");

endmodule

[src/sc2a_queue.sv]
module sc2a_queue
    import sc2a_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  job_t  push_job,
    output logic  full,
    input  logic  pop,
    output job_t  head_job,
    output logic  empty
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    job_t            slots [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign full     = (count_reg == CntW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("pop from empty queue");

endmodule

[src/sc2a_back.sv]
module sc2a_back
    import sc2a_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       empty,
    input  job_t       head_job,
    output logic       pop,
    sc2a_out_if.source chars
);

    job_t       job_reg;
    logic [1:0] idx_reg, idx_next;
    logic       busy_reg, busy_next;
    logic       fire;
    logic       at_last;

    assign at_last         = (idx_reg == job_reg.last_idx);
    assign fire            = chars.valid && chars.ready;
    assign chars.valid     = busy_reg;
    assign chars.character = job_reg.chars[idx_reg];
    assign chars.last      = at_last;

    always_comb
    begin
        pop       = 1'b0;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (!busy_reg || (fire && at_last))
        begin
            pop       = !empty;
            busy_next = !empty;
            idx_next  = 2'd0;
        end
        else if (fire)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= head_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> idx_reg <= job_reg.last_idx)
        else $error("character index past end of run");

endmodule

[src/scancode_to_ascii_translator.sv]
// Scan code set 1 to ASCII translator. Each input transaction is one raw scan code byte;
// each output transaction is one character, with last marking the final character of
// the run that byte produced (one character, a three- or four-character escape
// sequence, or nothing). A front stage tracks shift, ctrl and the extended prefix and
// accepts one byte per cycle until the queue is full; a queue of QUEUE_DEPTH runs feeds
// a back stage that sends one character per cycle while the output is ready. Bytes that
// emit at most one character stream at one per cycle; an escape key holds the output for
// its three or four characters. A run is held in a queue slot, then in the back's job_reg.
module scancode_to_ascii_translator
    import sc2a_pkg::*;
#(
    parameter int QUEUE_DEPTH = sc2a_pkg::QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    sc2a_in_if.sink  codes,
    sc2a_out_if.source chars
);

    logic push;
    logic pop;
    logic full;
    logic empty;
    job_t push_job;
    job_t head_job;

    sc2a_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .codes      (codes),
        .queue_full (full),
        .push       (push),
        .push_job   (push_job)
    );

    sc2a_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .head_job (head_job),
        .empty    (empty)
    );

    sc2a_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .head_job (head_job),
        .pop      (pop),
        .chars    (chars)
    );

endmodule
